// ===== rtl/ovss_pkg.sv =====
package ovss_pkg;

  localparam int SCORE_W = 32;
  localparam int PAGES_W = 31;
  localparam int TICK_W  = 32;
  localparam int HZ_W    = 4;

  localparam logic [HZ_W-1:0] HZ_SHIFT_RESET = 4'd7;
  // ticks -> seconds / 8 and ticks -> minutes (roughly /1024 of ticks per s)
  localparam logic [4:0] CPU_SEC_SHIFT = 5'd3;
  localparam logic [4:0] RUN_MIN_SHIFT = 5'd10;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROOT_CPU,
    ST_DIV_CPU,
    ST_ROOT_RUN1,
    ST_ROOT_RUN2,
    ST_DIV_RUN,
    ST_FINISH
  } seq_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } unit_status_t;

endpackage

// ===== rtl/ovss_if.sv =====
interface ovss_in_if #(
  parameter int ID_BITS = 15
);
  logic               valid;
  logic               ready;
  logic [ID_BITS-1:0] task_id;
  logic               has_memory_map;
  logic               already_dying;
  logic [30:0]        virtual_pages;
  logic [31:0]        cpu_ticks;
  logic [31:0]        start_tick;
  logic [31:0]        now_tick;
  logic               is_niced;
  logic               is_privileged;
  logic               has_raw_io;
  logic               last_task;

  modport source (
    output valid, task_id, has_memory_map, already_dying, virtual_pages, cpu_ticks,
           start_tick, now_tick, is_niced, is_privileged, has_raw_io, last_task,
    input  ready
  );
  modport sink (
    input  valid, task_id, has_memory_map, already_dying, virtual_pages, cpu_ticks,
           start_tick, now_tick, is_niced, is_privileged, has_raw_io, last_task,
    output ready
  );
endinterface

interface ovss_out_if #(
  parameter int ID_BITS = 15
);
  logic               valid;
  logic               ready;
  logic               victim_found;
  logic [ID_BITS-1:0] victim_id;
  logic [31:0]        victim_score;

  modport source (
    output valid, victim_found, victim_id, victim_score,
    input  ready
  );
  modport sink (
    input  valid, victim_found, victim_id, victim_score,
    output ready
  );
endinterface

// ===== rtl/oom_victim_score_select.sv =====
// OOM victim scorer / selector.
// tasks   : one task record per word (valid/ready). Accepted when valid and
//           ready are both high. ready is high only while the sequencer idles.
// victims : one word per scan, produced only for a record marked last_task:
//           found flag, id and score of the strictly highest nonzero score
//           (first task to reach it wins ties). After the report the running
//           maximum clears for the next scan.
// cfg     : cfg_we/cfg_wdata write hz_shift (log2 tick rate); only while idle.
// Sequence: an eligible task runs root(cpu_sec), a 32-step divide,
//   root(run_min), root of that, and a second 32-step divide, then an
//   update. The shift-per-cycle root unit and the bit-serial divider
//   are shared, so a task is taken only once the previous one has left
//   its update state. An ineligible task (id 0, no memory map, dying)
//   skips the roots and divides and goes straight to the update.
// Stall: the report sits in an output register; the next scan's records are
//   still accepted while it waits. Only a further last record holds in its
//   update state until the output register frees.
// Reset (rst, sync, high): hz_shift = 7, running maximum cleared, output
//   register empty, sequencer idle.
module oom_victim_score_select #(
  parameter int ID_BITS = 15
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [3:0]        cfg_wdata,
  ovss_in_if.sink           tasks,
  ovss_out_if.source        victims
);

  ovss_pkg::seq_state_t state, state_next;

  logic [ovss_pkg::HZ_W-1:0]    hz_shift;
  logic [ovss_pkg::SCORE_W-1:0] score;
  logic [31:0]                  run_min;
  logic [ID_BITS-1:0]           task_id;
  logic                         niced;
  logic                         priv;
  logic                         rawio;
  logic                         last_r;
  logic [ovss_pkg::SCORE_W-1:0] best_score;
  logic [ID_BITS-1:0]           best_task;

  logic                         out_valid;
  logic                         out_found;
  logic [ID_BITS-1:0]           out_id;
  logic [ovss_pkg::SCORE_W-1:0] out_score;

  logic        accept;
  logic        eligible;
  logic [4:0]  cpu_amt;
  logic [4:0]  run_amt;
  logic [31:0] cpu_sec_in;
  logic [31:0] run_min_in;
  logic        out_free;

  logic        root_start;
  logic [31:0] root_x;
  logic [31:0] root_res;
  ovss_pkg::unit_status_t root_st;

  logic        div_start;
  logic [31:0] div_dividend;
  logic [31:0] div_divisor;
  logic [31:0] div_q;
  ovss_pkg::unit_status_t div_st;

  logic [31:0] adj_nice;
  logic [31:0] adj_priv;
  logic [31:0] adj_final;

  logic                         better;
  logic [ovss_pkg::SCORE_W-1:0] new_best;
  logic [ID_BITS-1:0]           new_task;

  assign tasks.ready = (state == ovss_pkg::ST_IDLE);
  assign accept      = tasks.valid && tasks.ready;
  assign eligible    = (tasks.task_id != '0) && tasks.has_memory_map && !tasks.already_dying;

  // tick -> seconds / minutes scaling
  assign cpu_amt    = {1'b0, hz_shift} + ovss_pkg::CPU_SEC_SHIFT;
  assign run_amt    = {1'b0, hz_shift} + ovss_pkg::RUN_MIN_SHIFT;
  assign cpu_sec_in = tasks.cpu_ticks >> cpu_amt;
  assign run_min_in = (tasks.now_tick - tasks.start_tick) >> run_amt;

  assign out_free = !out_valid || victims.ready;

  // niced doubles (no overflow: 31-bit pages), each privilege term quarters
  always_comb begin
    adj_nice  = niced ? {div_q[30:0], 1'b0} : div_q;
    adj_priv  = priv  ? (adj_nice >> 2) : adj_nice;
    adj_final = rawio ? (adj_priv >> 2) : adj_priv;
  end

  always_comb begin
    better   = (score > best_score);
    new_best = better ? score : best_score;
    new_task = better ? task_id : best_task;
  end

  ovss_root u_root (
    .clk    (clk),
    .rst    (rst),
    .start  (root_start),
    .x_in   (root_x),
    .status (root_st),
    .result (root_res)
  );

  ovss_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (div_divisor),
    .status   (div_st),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ovss_pkg::ST_IDLE: begin
        if (accept) begin
          state_next = eligible ? ovss_pkg::ST_ROOT_CPU : ovss_pkg::ST_FINISH;
        end
      end
      ovss_pkg::ST_ROOT_CPU: begin
        if (root_st.done) state_next = ovss_pkg::ST_DIV_CPU;
      end
      ovss_pkg::ST_DIV_CPU: begin
        if (div_st.done) state_next = ovss_pkg::ST_ROOT_RUN1;
      end
      ovss_pkg::ST_ROOT_RUN1: begin
        if (root_st.done) state_next = ovss_pkg::ST_ROOT_RUN2;
      end
      ovss_pkg::ST_ROOT_RUN2: begin
        if (root_st.done) state_next = ovss_pkg::ST_DIV_RUN;
      end
      ovss_pkg::ST_DIV_RUN: begin
        if (div_st.done) state_next = ovss_pkg::ST_FINISH;
      end
      ovss_pkg::ST_FINISH: begin
        if (!last_r || out_free) state_next = ovss_pkg::ST_IDLE;
      end
      default: state_next = ovss_pkg::ST_IDLE;
    endcase
  end

  // unit launches and operand selection
  always_comb begin
    root_start   = 1'b0;
    root_x       = root_res;
    div_start    = 1'b0;
    div_dividend = score;
    div_divisor  = root_res;
    case (state)
      ovss_pkg::ST_IDLE: begin
        root_start = accept && eligible;
        root_x     = cpu_sec_in;
      end
      ovss_pkg::ST_ROOT_CPU:  div_start = root_st.done;
      ovss_pkg::ST_DIV_CPU: begin
        root_start = div_st.done;
        root_x     = run_min;
      end
      ovss_pkg::ST_ROOT_RUN1: root_start = root_st.done;
      ovss_pkg::ST_ROOT_RUN2: div_start  = root_st.done;
      default: begin
        root_start = 1'b0;
        div_start  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ovss_pkg::ST_IDLE;
      hz_shift   <= ovss_pkg::HZ_SHIFT_RESET;
      best_score <= '0;
      best_task  <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) hz_shift <= cfg_wdata;
      if (state == ovss_pkg::ST_FINISH) begin
        if (!last_r) begin
          best_score <= new_best;
          best_task  <= new_task;
        end else if (out_free) begin
          best_score <= '0;
          best_task  <= '0;
        end
      end
      if (state == ovss_pkg::ST_FINISH && last_r && out_free) begin
        out_valid <= 1'b1;
      end else if (victims.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // item payload and report word
  always_ff @(posedge clk) begin
    if (accept) begin
      score   <= eligible ? {1'b0, tasks.virtual_pages} : '0;
      run_min <= run_min_in;
      task_id <= tasks.task_id;
      niced   <= tasks.is_niced;
      priv    <= tasks.is_privileged;
      rawio   <= tasks.has_raw_io;
      last_r  <= tasks.last_task;
    end
    if (state == ovss_pkg::ST_DIV_CPU && div_st.done) score <= div_q;
    if (state == ovss_pkg::ST_DIV_RUN && div_st.done) score <= adj_final;
    if (state == ovss_pkg::ST_FINISH && last_r && out_free) begin
      out_found <= (new_best != '0);
      out_id    <= new_task;
      out_score <= new_best;
    end
  end

  assign victims.valid        = out_valid;
  assign victims.victim_found = out_found;
  assign victims.victim_id    = out_id;
  assign victims.victim_score = out_score;

  // a task is only taken while both shared units are quiet
  a_idle_units: assert property (@(posedge clk) disable iff (rst)
    tasks.ready |-> !(root_st.busy || div_st.busy))
    else $error("task accepted while a shared unit is busy");

  // the divider only finishes in a divide state
  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> (state == ovss_pkg::ST_DIV_CPU || state == ovss_pkg::ST_DIV_RUN))
    else $error("divider finished outside a divide state");

  // a nonzero best always belongs to a nonzero task id
  a_best_pair: assert property (@(posedge clk) disable iff (rst)
    (best_score == '0) == (best_task == '0))
    else $error("running maximum and its task disagree");

  // report flag matches the score it carries
  a_found_flag: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_found == (out_score != '0)))
    else $error("victim_found inconsistent with victim_score");

endmodule

// ===== rtl/ovss_root.sv =====
// Rough root: shift x by 2 and r by 1 per cycle until x <= 1.
module ovss_root (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 x_in,
  output ovss_pkg::unit_status_t      status,
  output logic [31:0]                 result
);

  logic [31:0] x;
  logic [31:0] r;
  logic        busy;
  logic        done;
  logic        settled;
  logic [31:0] adj;
  logic [31:0] fin;

  assign settled = (x[31:1] == 31'd0);

  always_comb begin
    adj = (x != 32'd0) ? (r - (r >> 2)) : r;
    fin = (adj == 32'd0) ? 32'd1 : adj;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && settled) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x <= x_in;
      r <= x_in;
    end else if (busy && !settled) begin
      x <= x >> 2;
      r <= r >> 1;
    end
    if (!start && busy && settled) begin
      result <= fin;
    end
  end

  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== rtl/ovss_div.sv =====
// Restoring divider, one quotient bit per cycle.
module ovss_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [31:0]                 dividend,
  input  logic [31:0]                 divisor,
  output ovss_pkg::unit_status_t      status,
  output logic [31:0]                 quotient
);

  logic [31:0] q;
  logic [31:0] rem;
  logic [31:0] dvs;
  logic [4:0]  cnt;
  logic        busy;
  logic        done;
  logic [32:0] trial;

  assign trial = {rem, q[31]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= 5'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd0;
      end else if (busy) begin
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q   <= dividend;
      rem <= 32'd0;
      dvs <= divisor;
    end else if (busy) begin
      if (!trial[32]) begin
        rem <= trial[31:0];
        q   <= {q[30:0], 1'b1};
      end else begin
        rem <= {rem[30:0], q[31]};
        q   <= {q[30:0], 1'b0};
      end
    end
  end

  assign quotient    = q;
  assign status.busy = busy;
  assign status.done = done;

endmodule

// ===== dv/ovss_checker.sv =====
// Watches the task and victim channels, scores each accepted task record and
// checks every victim report against the predicted one.
module ovss_checker #(
  parameter int ID_BITS = 15
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [ovss_pkg::HZ_W-1:0] cfg_wdata,
  ovss_in_if                        tasks,
  ovss_out_if                       victims,
  output int                        fail_count,
  output int                        pending,
  output int                        reports,
  output int                        found_reports
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic                         found;
    logic [ID_BITS-1:0]           id;
    logic [ovss_pkg::SCORE_W-1:0] score;
  } victim_t;

  victim_t                      victim_q[$];
  logic [ovss_pkg::HZ_W-1:0]    hz_shift;
  logic [ovss_pkg::SCORE_W-1:0] best_score;
  logic [ID_BITS-1:0]           best_id;

  // shift-and-halve root estimate, never below 1
  function automatic logic [31:0] coarse_root(input logic [31:0] x);
    logic [31:0] v;
    logic [31:0] r;
    v = x;
    r = x;
    while (v > 32'd1) begin
      v = v >> 2;
      r = r >> 1;
    end
    if (v != 32'd0) r = r - (r >> 2);
    return (r != 32'd0) ? r : 32'd1;
  endfunction

  function automatic logic [ovss_pkg::SCORE_W-1:0] badness(
    input logic [ovss_pkg::HZ_W-1:0]    hz,
    input logic [ID_BITS-1:0]           id,
    input logic                         mm,
    input logic                         dying,
    input logic [ovss_pkg::PAGES_W-1:0] pages,
    input logic [ovss_pkg::TICK_W-1:0]  cpu,
    input logic [ovss_pkg::TICK_W-1:0]  start,
    input logic [ovss_pkg::TICK_W-1:0]  now,
    input logic                         niced,
    input logic                         priv,
    input logic                         rawio
  );
    logic [ovss_pkg::TICK_W-1:0]  cpu_sec;
    logic [ovss_pkg::TICK_W-1:0]  run_ticks;
    logic [ovss_pkg::TICK_W-1:0]  run_min;
    logic [ovss_pkg::SCORE_W-1:0] s;
    if (id == '0 || !mm || dying) return '0;
    cpu_sec   = cpu >> (int'(hz) + int'(ovss_pkg::CPU_SEC_SHIFT));
    run_ticks = now - start;
    run_min   = run_ticks >> (int'(hz) + int'(ovss_pkg::RUN_MIN_SHIFT));
    s = ovss_pkg::SCORE_W'(pages);
    s = s / coarse_root(cpu_sec);
    s = s / coarse_root(coarse_root(run_min));
    if (niced) s = s << 1;
    if (priv)  s = s >> 2;
    if (rawio) s = s >> 2;
    return s;
  endfunction

  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: victim %s mismatch, expected %0d, got %0d", $time, name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    logic [ovss_pkg::SCORE_W-1:0] s;
    victim_t                      want;
    if (rst) begin
      hz_shift      = ovss_pkg::HZ_SHIFT_RESET;
      best_score    = '0;
      best_id       = '0;
      fail_count    = 0;
      reports       = 0;
      found_reports = 0;
      victim_q.delete();
    end else begin
      // report side first: it can never belong to a record taken this edge
      if (victims.valid && victims.ready) begin
        reports++;
        if (victims.victim_found) found_reports++;
        if (victim_q.size() == 0) begin
          $display("%0t: unexpected victim report, expected none, got found=%0b id=%0d score=%0d",
                   $time, victims.victim_found, victims.victim_id, victims.victim_score);
          fail_count++;
        end else begin
          want = victim_q.pop_front();
          check_field("found", 32'(want.found), 32'(victims.victim_found));
          check_field("id", 32'(want.id), 32'(victims.victim_id));
          check_field("score", 32'(want.score), 32'(victims.victim_score));
        end
      end
      if (tasks.valid && tasks.ready) begin
        s = badness(hz_shift, tasks.task_id, tasks.has_memory_map, tasks.already_dying,
                    tasks.virtual_pages, tasks.cpu_ticks, tasks.start_tick, tasks.now_tick,
                    tasks.is_niced, tasks.is_privileged, tasks.has_raw_io);
        // strictly greater: first task at a given score keeps it
        if (s > best_score) begin
          best_score = s;
          best_id    = tasks.task_id;
        end
        if (tasks.last_task) begin
          want.found = (best_score != '0);
          want.id    = best_id;
          want.score = best_score;
          victim_q.push_back(want);
          best_score = '0;
          best_id    = '0;
        end
      end
      if (cfg_we) hz_shift = cfg_wdata;
    end
    pending = victim_q.size();
  end

endmodule

// ===== dv/testbench.sv =====
// Stimulus and verdict for the victim selector. The checker beside the block
// does all prediction; this module only feeds task records, plays the
// victim receiver and rewrites hz_shift between phases.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ID_BITS = 15;
  // settle time after the last report, with margin over the slowest task
  localparam int SETTLE  = 150;
  localparam int HOLD_LEN = 2500;

  typedef struct packed {
    logic [ID_BITS-1:0]           id;
    logic                         mm;
    logic                         dying;
    logic [ovss_pkg::PAGES_W-1:0] pages;
    logic [ovss_pkg::TICK_W-1:0]  cpu;
    logic [ovss_pkg::TICK_W-1:0]  start;
    logic [ovss_pkg::TICK_W-1:0]  now;
    logic                         niced;
    logic                         priv;
    logic                         rawio;
    logic                         last;
  } task_rec_t;

  logic                      clk;
  logic                      rst;
  logic                      cfg_we;
  logic [ovss_pkg::HZ_W-1:0] cfg_wdata;

  int fail_count, pending, reports, found_reports;
  int words_sent, scans_sent, settings_used;
  int burst_left;
  int hold_req_n;

  ovss_in_if  #(.ID_BITS(ID_BITS)) tasks_ch ();
  ovss_out_if #(.ID_BITS(ID_BITS)) victims_ch ();

  oom_victim_score_select #(.ID_BITS(ID_BITS)) u_top (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .tasks    (tasks_ch),
    .victims  (victims_ch)
  );

  ovss_checker #(.ID_BITS(ID_BITS)) u_checker (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .tasks        (tasks_ch),
    .victims      (victims_ch),
    .fail_count   (fail_count),
    .pending      (pending),
    .reports      (reports),
    .found_reports(found_reports)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // hard stop, several times the slowest legal run
  initial begin
    #10_000_000;
    $display("simulation failed");
    $finish;
  end

  function automatic task_rec_t mk(
    input logic [ID_BITS-1:0]           id,
    input logic                         mm,
    input logic                         dying,
    input logic [ovss_pkg::PAGES_W-1:0] pages,
    input logic [ovss_pkg::TICK_W-1:0]  cpu,
    input logic [ovss_pkg::TICK_W-1:0]  start,
    input logic [ovss_pkg::TICK_W-1:0]  now,
    input logic                         niced,
    input logic                         priv,
    input logic                         rawio,
    input logic                         last
  );
    task_rec_t r;
    r.id = id; r.mm = mm; r.dying = dying; r.pages = pages;
    r.cpu = cpu; r.start = start; r.now = now;
    r.niced = niced; r.priv = priv; r.rawio = rawio; r.last = last;
    return r;
  endfunction

  // Random task record. Sizes and tick counts are spread over many octaves
  // so that both roots see everything from 0 to huge values.
  function automatic task_rec_t rand_rec();
    task_rec_t                   r;
    logic [ovss_pkg::TICK_W-1:0] delta;
    case ($urandom_range(0, 15))
      0:       r.id = '0;
      1:       r.id = '1;
      default: r.id = ID_BITS'($urandom_range(1, (1 << ID_BITS) - 1));
    endcase
    r.mm    = ($urandom_range(0, 9) != 0);
    r.dying = ($urandom_range(0, 9) == 0);
    case ($urandom_range(0, 7))
      0:       r.pages = '0;
      1:       r.pages = '1;
      2, 3:    r.pages = ovss_pkg::PAGES_W'($urandom_range(0, 4095));
      default: r.pages = ovss_pkg::PAGES_W'($urandom);
    endcase
    case ($urandom_range(0, 7))
      0:       r.cpu = '0;
      1:       r.cpu = '1;
      default: r.cpu = $urandom >> $urandom_range(0, 31);
    endcase
    case ($urandom_range(0, 7))
      0:       delta = '0;
      1:       delta = '1;
      default: delta = $urandom >> $urandom_range(0, 31);
    endcase
    r.start = $urandom;
    r.now   = r.start + delta;   // wraps on purpose
    r.niced = 1'($urandom_range(0, 1));
    r.priv  = ($urandom_range(0, 3) == 0);
    r.rawio = ($urandom_range(0, 3) == 0);
    r.last  = 1'b0;
    return r;
  endfunction

  // Offer one word; bursts of random length with random gaps between them.
  task automatic push_task(input task_rec_t r);
    int gap;
    if (burst_left == 0) begin
      if ($urandom_range(0, 9) == 0) begin
        burst_left = $urandom_range(30, 60);  // a long run with no idling
        gap = 0;
      end else begin
        burst_left = $urandom_range(1, 12);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
      end
      if (gap > 0) begin
        tasks_ch.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    tasks_ch.valid          <= 1'b1;
    tasks_ch.task_id        <= r.id;
    tasks_ch.has_memory_map <= r.mm;
    tasks_ch.already_dying  <= r.dying;
    tasks_ch.virtual_pages  <= r.pages;
    tasks_ch.cpu_ticks      <= r.cpu;
    tasks_ch.start_tick     <= r.start;
    tasks_ch.now_tick       <= r.now;
    tasks_ch.is_niced       <= r.niced;
    tasks_ch.is_privileged  <= r.priv;
    tasks_ch.has_raw_io     <= r.rawio;
    tasks_ch.last_task      <= r.last;
    do @(posedge clk); while (!tasks_ch.ready);
    words_sent++;
    if (r.last) scans_sent++;
  endtask

  // Let every report come out, let a record with no report finish, then
  // rewrite the tick rate while the block sits idle.
  task automatic settle_and_config(input logic [ovss_pkg::HZ_W-1:0] hz);
    tasks_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= hz;
    @(posedge clk);
    cfg_we    <= 1'b0;
    settings_used++;
  endtask

  // Well-formed scans with random content; ties are made by repeating the
  // previous record under another id.
  task automatic run_scans(input int n_words, input bit flood);
    task_rec_t r;
    task_rec_t prev;
    int        len;
    int        done_words;
    bit        flooded;
    done_words = 0;
    flooded    = 1'b0;
    prev       = rand_rec();
    while (done_words < n_words) begin
      if (flood && !flooded && done_words > 50) begin
        // receiver goes quiet; short scans pile up behind the output register
        flooded = 1'b1;
        hold_req_n <= hold_req_n + 1;
        repeat (6) begin
          len = $urandom_range(1, 2);
          for (int i = 0; i < len; i++) begin
            r = rand_rec();
            r.mm = 1'b1;
            r.dying = 1'b0;
            if (r.id == '0) r.id = ID_BITS'(1);
            r.last = (i == len - 1);
            push_task(r);
            done_words++;
          end
        end
      end
      len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30) : $urandom_range(1, 6);
      for (int i = 0; i < len; i++) begin
        if ($urandom_range(0, 7) == 0) begin
          r = prev;
          r.id = ID_BITS'($urandom_range(1, (1 << ID_BITS) - 1));
        end else begin
          r = rand_rec();
        end
        r.last = (i == len - 1);
        push_task(r);
        prev = r;
        done_words++;
      end
    end
  endtask

  // Victim receiver: changing stall modes, plus a long hold-off on request.
  initial begin
    int mode;
    int left;
    int hold_left;
    int hold_seen;
    mode = 0;
    left = 0;
    hold_left = 0;
    hold_seen = 0;
    victims_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_seen != hold_req_n) begin
        hold_seen = hold_req_n;
        hold_left = HOLD_LEN;
      end
      if (left == 0) begin
        mode = $urandom_range(0, 3);
        left = $urandom_range(16, 128);
      end else begin
        left--;
      end
      if (hold_left > 0) begin
        hold_left--;
        victims_ch.ready <= 1'b0;
      end else begin
        case (mode)
          0:       victims_ch.ready <= 1'b1;
          1:       victims_ch.ready <= 1'($urandom_range(0, 1));
          2:       victims_ch.ready <= ($urandom_range(0, 3) == 0);
          default: victims_ch.ready <= ((left % 8) < 3);
        endcase
      end
    end
  end

  initial begin
    logic [ovss_pkg::HZ_W-1:0]    hz_plan[6];
    logic [ovss_pkg::PAGES_W-1:0] pmax;
    pmax = '1;
    words_sent    = 0;
    scans_sent    = 0;
    settings_used = 1;   // reset value counts as the first
    burst_left    = 0;
    hold_req_n    <= 0;
    rst           <= 1'b1;
    cfg_we        <= 1'b0;
    cfg_wdata     <= '0;
    tasks_ch.valid          <= 1'b0;
    tasks_ch.task_id        <= '0;
    tasks_ch.has_memory_map <= 1'b0;
    tasks_ch.already_dying  <= 1'b0;
    tasks_ch.virtual_pages  <= '0;
    tasks_ch.cpu_ticks      <= '0;
    tasks_ch.start_tick     <= '0;
    tasks_ch.now_tick       <= '0;
    tasks_ch.is_niced       <= 1'b0;
    tasks_ch.is_privileged  <= 1'b0;
    tasks_ch.has_raw_io     <= 1'b0;
    tasks_ch.last_task      <= 1'b0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part, hz_shift still at its reset value
    // idle task, no memory map and dying task all score zero
    push_task(mk('0, 1, 0, pmax, 0, 0, 0, 1, 0, 0, 0));
    push_task(mk(15'd5, 0, 0, pmax, 0, 0, 0, 1, 0, 0, 0));
    push_task(mk(15'd6, 1, 1, pmax, 0, 0, 0, 1, 0, 0, 0));
    // largest pages doubled: widest possible score
    push_task(mk('1, 1, 0, pmax, 0, 0, 0, 1, 0, 0, 1));
    // eligible but zero pages: scan with no victim
    push_task(mk(15'd9, 1, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    // tie: second record with the same score must not win
    push_task(mk(15'd100, 1, 0, 31'd1000, 32'd5000, 0, 32'd2_000_000, 0, 0, 0, 0));
    push_task(mk(15'd200, 1, 0, 31'd1000, 32'd5000, 0, 32'd2_000_000, 0, 0, 0, 0));
    push_task(mk(15'd300, 1, 0, 31'd999, 32'd5000, 0, 32'd2_000_000, 0, 0, 0, 0));
    push_task(mk('0, 1, 0, pmax, 0, 0, 0, 0, 0, 0, 1));
    // privilege quarters, wrapped run time, saturated CPU
    push_task(mk(15'd77, 1, 0, pmax, '1, '1, 0, 1, 1, 1, 0));
    push_task(mk(15'd78, 1, 0, 31'd12345, 32'd1000, 32'd100, 32'd50, 0, 1, 0, 0));
    push_task(mk(15'd79, 1, 0, pmax, 0, 0, '1, 0, 0, 1, 1));
    // every bit set, dying included, then every bit clear
    push_task(mk('1, 1, 1, pmax, '1, '1, '1, 1, 1, 1, 1));
    push_task(mk('0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    // later strictly larger score replaces the earlier one
    push_task(mk(15'd10, 1, 0, 31'd50, 0, 0, 0, 0, 0, 0, 0));
    push_task(mk(15'd11, 1, 0, 31'd60, 0, 0, 0, 0, 0, 0, 0));
    push_task(mk(15'd12, 0, 0, pmax, 0, 0, 0, 1, 0, 0, 1));

    // random phases over several tick rates, both extremes included
    hz_plan[0] = '0;
    hz_plan[1] = '1;
    hz_plan[2] = ovss_pkg::HZ_W'($urandom_range(1, 14));
    hz_plan[3] = ovss_pkg::HZ_SHIFT_RESET;
    hz_plan[4] = ovss_pkg::HZ_W'($urandom_range(0, 15));
    hz_plan[5] = '0;
    for (int p = 0; p < 6; p++) begin
      settle_and_config(hz_plan[p]);
      run_scans(222, p == 2);
    end

    tasks_ch.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    if (pending != 0)
      $display("%0t: %0d expected victim report(s) never arrived", $time, pending);
    $display("covered %0d task words in %0d scans under %0d tick-rate settings",
             words_sent, scans_sent, settings_used);
    $display("checked %0d victim reports, %0d of them naming a victim", reports, found_reports);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ovss_pkg.sv
rtl/ovss_if.sv
rtl/ovss_root.sv
rtl/ovss_div.sv
rtl/oom_victim_score_select.sv
dv/ovss_checker.sv
dv/testbench.sv
